// ----- src/chm_pkg.sv -----
`timescale 1ns / 1ps
package chm_pkg;

  localparam int BUCKETS    = 256;
  localparam int POOL_NODES = 1024;
  localparam int KEY_BITS   = 64;

  localparam int VAL_W   = 64;
  localparam int COUNT_W = 11;
  localparam int PTR_W   = $clog2(POOL_NODES + 1);
  localparam int NODE_AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int BKT_AW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;

  // end-of-chain / no-node marker
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
    logic [BKT_AW-1:0]   bucket;
  } chm_req_t;

  typedef struct packed {
    logic               found;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic               pool_full;
  } chm_rsp_t;

endpackage

// ----- src/chm_ram.sv -----
`timescale 1ns / 1ps
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/chm_front.sv -----
`timescale 1ns / 1ps
module chm_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [chm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               q_valid,
  input  logic                               q_ready,
  output chm_pkg::chm_req_t                  q_req
);
  import chm_pkg::*;

  chm_req_t          slot_r [2];
  logic [1:0]        cnt_r, cnt_nxt;
  logic              wr_ptr_r, rd_ptr_r;
  chm_req_t          req_in;
  logic [KEY_BITS-1:0] key_m, rem;
  logic              push, pop;

  // take the key and pick its bucket (key modulo BUCKETS) on entry
  always_comb begin
    key_m         = in_tdata[2 +: KEY_BITS];
    rem           = key_m % KEY_BITS'(BUCKETS);
    req_in.op     = in_tdata[1:0];
    req_in.key    = key_m;
    req_in.value  = in_tdata[66 +: VAL_W];
    req_in.bucket = BKT_AW'(rem);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_req     = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= req_in;
    end
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

endmodule

// ----- src/chm_back.sv -----
`timescale 1ns / 1ps
module chm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  chm_pkg::chm_req_t  q_req,
  output logic               out_valid,
  input  logic               out_ready,
  output chm_pkg::chm_rsp_t  out_rsp
);
  import chm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BKT  = 3'd1;
  localparam logic [2:0] ST_LINK = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_FREE = 3'd4;

  logic [2:0]         st_r, st_nxt;
  chm_req_t           req_r, req_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt, n_r, n_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [PTR_W-1:0]   free_r, free_nxt, fresh_r, fresh_nxt, count_r, count_nxt;
  logic [BUCKETS-1:0] bvld_r, bvld_nxt;
  logic               out_vld_r, out_vld_nxt;
  chm_rsp_t           rsp_r, rsp_nxt;

  // ram ports
  logic                hd_we, tl_we, bk_re, kv_we, nx_we, kv_re, nx_re;
  logic [BKT_AW-1:0]   bk_raddr;
  logic [PTR_W-1:0]    hd_wdata, tl_wdata, nx_wdata, head_q, tail_q, next_q;
  logic [NODE_AW-1:0]  kv_waddr, kv_raddr, nx_waddr, nx_raddr;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]    value_q;

  logic               out_free, emit, e_found, e_full, alloc;
  logic [VAL_W-1:0]   e_value;
  logic [PTR_W-1:0]   head_eff, tail_eff, n_sel;

  assign out_free = !out_vld_r || out_ready;
  assign head_eff = bvld_r[req_r.bucket] ? head_q : NIL;
  assign tail_eff = bvld_r[req_r.bucket] ? tail_q : NIL;

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    tail_nxt  = tail_r;
    n_nxt     = n_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    count_nxt = count_r;
    bvld_nxt  = bvld_r;
    q_ready   = 1'b0;
    hd_we = 1'b0; tl_we = 1'b0; bk_re = 1'b0;
    kv_we = 1'b0; kv_re = 1'b0; nx_we = 1'b0; nx_re = 1'b0;
    bk_raddr = q_req.bucket;
    hd_wdata = NIL; tl_wdata = NIL; nx_wdata = NIL;
    kv_waddr = n_r[NODE_AW-1:0];
    kv_raddr = cur_r[NODE_AW-1:0];
    nx_waddr = n_r[NODE_AW-1:0];
    nx_raddr = free_r[NODE_AW-1:0];
    emit = 1'b0; e_found = 1'b0; e_full = 1'b0; e_value = '0;
    alloc = 1'b0;
    n_sel = free_r;

    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_req.op == OP_CLEAR) begin
            if (out_free) begin
              q_ready   = 1'b1;
              free_nxt  = NIL;
              fresh_nxt = '0;
              count_nxt = '0;
              bvld_nxt  = '0;
              emit      = 1'b1;
            end
          end else begin
            q_ready = 1'b1;
            req_nxt = q_req;
            bk_re   = 1'b1;
            nx_re   = 1'b1;
            st_nxt  = ST_BKT;
          end
        end
      end
      ST_BKT: begin
        if (out_free) begin
          if (req_r.op == OP_INSERT) begin
            if (free_r != NIL) begin
              alloc    = 1'b1;
              n_sel    = free_r;
              free_nxt = next_q;
            end else if (fresh_r < PTR_W'(POOL_NODES)) begin
              alloc     = 1'b1;
              n_sel     = fresh_r;
              fresh_nxt = fresh_r + PTR_W'(1);
            end
            if (alloc) begin
              kv_we    = 1'b1;
              kv_waddr = n_sel[NODE_AW-1:0];
              nx_we    = 1'b1;
              nx_waddr = n_sel[NODE_AW-1:0];
              nx_wdata = NIL;
              hd_we    = (head_eff == NIL);
              hd_wdata = n_sel;
              tl_we    = 1'b1;
              tl_wdata = n_sel;
              bvld_nxt[req_r.bucket] = 1'b1;
              count_nxt = count_r + PTR_W'(1);
              n_nxt    = n_sel;
              tail_nxt = tail_eff;
              if (tail_eff != NIL) begin
                st_nxt = ST_LINK;
              end else begin
                emit   = 1'b1;
                st_nxt = ST_IDLE;
              end
            end else begin
              emit   = 1'b1;
              e_full = 1'b1;
              st_nxt = ST_IDLE;
            end
          end else begin
            if (head_eff == NIL) begin
              emit   = 1'b1;
              st_nxt = ST_IDLE;
            end else begin
              cur_nxt  = head_eff;
              prev_nxt = NIL;
              tail_nxt = tail_eff;
              kv_re    = 1'b1;
              kv_raddr = head_eff[NODE_AW-1:0];
              nx_re    = 1'b1;
              nx_raddr = head_eff[NODE_AW-1:0];
              st_nxt   = ST_WALK;
            end
          end
        end
      end
      ST_LINK: begin
        if (out_free) begin
          nx_we    = 1'b1;
          nx_waddr = tail_r[NODE_AW-1:0];
          nx_wdata = n_r;
          emit     = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (key_q == req_r.key) begin
            if (req_r.op == OP_FIND) begin
              emit    = 1'b1;
              e_found = 1'b1;
              e_value = value_q;
              st_nxt  = ST_IDLE;
            end else begin
              // unlink the matching node
              if (prev_r != NIL) begin
                nx_we    = 1'b1;
                nx_waddr = prev_r[NODE_AW-1:0];
                nx_wdata = next_q;
              end else begin
                hd_we    = 1'b1;
                hd_wdata = next_q;
              end
              if (tail_r == cur_r) begin
                tl_we    = 1'b1;
                tl_wdata = prev_r;
              end
              if (count_r != '0) count_nxt = count_r - PTR_W'(1);
              st_nxt = ST_FREE;
            end
          end else if (next_q == NIL) begin
            emit   = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            prev_nxt = cur_r;
            cur_nxt  = next_q;
            kv_re    = 1'b1;
            kv_raddr = next_q[NODE_AW-1:0];
            nx_re    = 1'b1;
            nx_raddr = next_q[NODE_AW-1:0];
          end
        end
      end
      ST_FREE: begin
        if (out_free) begin
          nx_we    = 1'b1;
          nx_waddr = cur_r[NODE_AW-1:0];
          nx_wdata = free_r;
          free_nxt = cur_r;
          emit     = 1'b1;
          e_found  = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (st_r != ST_IDLE) bk_raddr = req_r.bucket;

    rsp_nxt     = rsp_r;
    out_vld_nxt = out_vld_r && !out_ready;
    if (emit) begin
      out_vld_nxt       = 1'b1;
      rsp_nxt.found     = e_found;
      rsp_nxt.value     = e_value;
      rsp_nxt.count     = COUNT_W'(count_nxt);
      rsp_nxt.pool_full = e_full;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    tail_r <= tail_nxt;
    n_r    <= n_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    rsp_r  <= rsp_nxt;
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      free_r    <= NIL;
      fresh_r   <= '0;
      count_r   <= '0;
      bvld_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      free_r    <= free_nxt;
      fresh_r   <= fresh_nxt;
      count_r   <= count_nxt;
      bvld_r    <= bvld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = rsp_r;

  chm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(hd_we), .waddr(req_r.bucket), .wdata(hd_wdata),
    .re(bk_re), .raddr(bk_raddr), .rdata(head_q)
  );

  chm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_tail (
    .clk(clk), .we(tl_we), .waddr(req_r.bucket), .wdata(tl_wdata),
    .re(bk_re), .raddr(bk_raddr), .rdata(tail_q)
  );

  chm_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_key (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(req_r.key),
    .re(kv_re), .raddr(kv_raddr), .rdata(key_q)
  );

  chm_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_value (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(req_r.value),
    .re(kv_re), .raddr(kv_raddr), .rdata(value_q)
  );

  chm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(next_q)
  );

endmodule

// ----- src/chained_hash_map_engine.sv -----
`timescale 1ns / 1ps
// channel  | dir | tdata fields, lowest bit first
// in_      | in  | operation[1:0], key[65:2], value_in[129:66], zero pad to 136
// out_     | out | found[0], value_out[64:1], entry_count[75:65], pool_full[76], pad to 80
//
// one operation at a time in the back end: clear is done in the idle state,
// insert reads the bucket and links onto a non-empty chain, find and erase
// walk the chain, an erase hit then frees the node; the rate is set by the
// walk over the node memories, one node read per cycle while the result
// register is free; no clearing pass: bucket valid bits and a fresh-node
// counter restore the empty map at reset and on clear; a two-entry input
// queue keeps taking transfers while the result register waits on out_tready
module chained_hash_map_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // operation, key, value_in
  input  logic [chm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found, value_out, entry_count, pool_full
  output logic [chm_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import chm_pkg::*;

  // front-to-back request queue
  logic     q_valid, q_ready;
  chm_req_t q_req;
  chm_rsp_t rsp;

  chm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  // sequencer over bucket and node memories, owns the result register
  chm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_rsp(rsp)
  );

  // pack the result transfer, zero pad to whole bytes
  assign out_tdata = {3'b000, rsp.pool_full, rsp.count, rsp.value, rsp.found};

endmodule

// ----- verif/chm_checker.sv -----
`timescale 1ns / 1ps
module chm_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [chm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [chm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                               fail_count,
  output int                               pending
);
  import chm_pkg::*;

  typedef struct {
    logic               found;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic               full;
  } map_result_t;

  // chain model: each bucket holds its live entries oldest first
  logic [KEY_BITS-1:0] chain_key[BUCKETS][$];
  logic [VAL_W-1:0]    chain_val[BUCKETS][$];
  int                  live_entries;
  map_result_t         result_q[$];

  assign pending = result_q.size();

  function automatic map_result_t apply_op(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                           logic [VAL_W-1:0] val);
    map_result_t r;
    int b;
    r = '{1'b0, '0, '0, 1'b0};
    b = int'(key % BUCKETS);
    case (op)
      OP_INSERT: begin
        if (live_entries >= POOL_NODES) r.full = 1'b1;
        else begin
          chain_key[b].push_back(key);
          chain_val[b].push_back(val);
          live_entries++;
        end
      end
      OP_ERASE: begin
        foreach (chain_key[b][i]) begin
          if (chain_key[b][i] == key) begin
            chain_key[b].delete(i);
            chain_val[b].delete(i);
            live_entries--;
            r.found = 1'b1;
            break;
          end
        end
      end
      OP_FIND: begin
        foreach (chain_key[b][i]) begin
          if (chain_key[b][i] == key) begin
            r.found = 1'b1;
            r.value = chain_val[b][i];
            break;
          end
        end
      end
      default: begin
        for (int i = 0; i < BUCKETS; i++) begin
          chain_key[i].delete();
          chain_val[i].delete();
        end
        live_entries = 0;
      end
    endcase
    r.count = COUNT_W'(live_entries);
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count   <= 0;
      live_entries = 0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        result_q.push_back(apply_op(in_tdata[1:0], in_tdata[65:2], in_tdata[129:66]));
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transfer %h", out_tdata);
          errs++;
        end else begin
          e = result_q.pop_front();
          if (out_tdata[0] !== e.found) begin
            $error("found: expected %0d actual %0d", e.found, out_tdata[0]);
            errs++;
          end
          if (out_tdata[64:1] !== e.value) begin
            $error("value_out: expected %h actual %h", e.value, out_tdata[64:1]);
            errs++;
          end
          if (out_tdata[75:65] !== e.count) begin
            $error("entry_count: expected %0d actual %0d", e.count, out_tdata[75:65]);
            errs++;
          end
          if (out_tdata[76] !== e.full) begin
            $error("pool_full: expected %0d actual %0d", e.full, out_tdata[76]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- verif/tb_chained_hash_map_engine.sv -----
`timescale 1ns / 1ps
module tb_chained_hash_map_engine;
  import chm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int fail_count;
  int pending;
  // receiver hold-off request, served by the ready process
  bit hold_receiver = 1'b0;
  int hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_hash_map_engine dut (.*);

  chm_checker checker_i (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one transfer on the input channel, launched at a falling edge;
  // valid stays up into the next call when no gap follows
  task automatic send_op(logic [1:0] op, logic [63:0] key, logic [63:0] val);
    int g;
    g = gap_len();
    if (g > 0 && $urandom_range(0, 3) == 0) g = 0;  // stretches with no gaps
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata  <= {6'b0, val, key, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // ready side: random stalls, plus a long hold-off when asked
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_tready <= 1'b0;
        for (int c = 0; c < hold_cycles; c++) @(negedge clk);
        hold_receiver = 1'b0;
        out_tready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // keys mostly from a small pool so hits, duplicates and long chains happen
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: k = 64'($urandom_range(0, 40)) * 256 + 64'($urandom_range(0, 3));
      default: k = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 32'($urandom_range(0, 30))};
    endcase
    return k;
  endfunction

  initial begin
    logic [1:0] op;
    int p;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, duplicates, misses, clear
    send_op(OP_FIND, 64'h0, 64'h0);
    send_op(OP_ERASE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_op(OP_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_op(OP_INSERT, 64'h100, 64'h1111);   // same bucket as key zero
    send_op(OP_INSERT, 64'h0, 64'h2222);     // duplicate key
    send_op(OP_FIND, 64'h0, 64'hDEAD);
    send_op(OP_FIND, 64'h100, 64'h0);
    send_op(OP_ERASE, 64'h0, 64'h0);
    send_op(OP_FIND, 64'h0, 64'h0);          // now the newer duplicate
    send_op(OP_ERASE, 64'h100, 64'h0);
    send_op(OP_ERASE, 64'h100, 64'h0);       // absent
    send_op(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_op(OP_CLEAR, 64'h5555, 64'hAAAA);
    send_op(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_op(OP_CLEAR, 64'h0, 64'h0);

    // long receiver hold-off while the sender keeps offering
    hold_cycles = 200;
    hold_receiver = 1'b1;
    for (int i = 0; i < 12; i++) send_op(OP_INSERT, pick_key(), {$urandom, $urandom});
    wait_drained();  // sender pauses until all results are in

    // fill the pool past its end, then probe with finds and empty it by clear
    for (int i = 0; i < POOL_NODES + 4; i++)
      send_op(OP_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
    for (int i = 0; i < 20; i++) send_op(OP_FIND, pick_key(), 64'h0);
    send_op(OP_CLEAR, 64'h0, 64'h0);

    // random mix biased toward insert and erase
    for (int i = 0; i < 220; i++) begin
      p = $urandom_range(0, 99);
      op = (p < 40) ? OP_INSERT : (p < 65) ? OP_FIND : (p < 98) ? OP_ERASE : OP_CLEAR;
      send_op(op, pick_key(), {$urandom, $urandom});
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("tb_chained_hash_map_engine: done, clean");
    else $display("tb_chained_hash_map_engine: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb_chained_hash_map_engine: done, errors");
    $finish;
  end
endmodule
